>>> rtl/ecnaw_pkg.sv
// ----------------------------------------------------------------------------
// ecnaw_pkg
// shared types and constants of the ecn alpha and window update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecnaw_pkg;

  localparam int ACK_W      = 62;
  localparam int CNT_W      = 40;
  localparam int BYTES_W    = 24;
  localparam int WIN_W      = 48;
  localparam int ALPHA_W    = 11;
  localparam int MSS_W      = 16;
  localparam int MINW_W     = 21;
  localparam int INITW_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int OPND_W = 64;
  localparam int DVSR_W = 48;
  localparam int STEP_W = 7;

  localparam logic [MSS_W-1:0]   MSS_RST   = 16'd1280;
  localparam logic [MINW_W-1:0]  MINW_RST  = 21'd2560;
  localparam logic [INITW_W-1:0] INITW_RST = 24'd15360;

  localparam logic [CFG_IDX_W-1:0] CFG_MSS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITW = 2'd2;

  // fraction scale 1024 and cut scale 2048 as shifts
  localparam int FRAC_SHIFT = 10;
  localparam int CUT_SHIFT  = 11;

  localparam logic [ALPHA_W-1:0] ALPHA_HALF = 11'd512;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 11'd1024;

  // iteration counts of the shared unit, one bit per cycle
  localparam logic [STEP_W-1:0] STEPS_FRAC_DIV = STEP_W'(CNT_W + FRAC_SHIFT);
  localparam logic [STEP_W-1:0] STEPS_CUT_MUL  = STEP_W'(ALPHA_W);
  localparam logic [STEP_W-1:0] STEPS_GOOD_MUL = STEP_W'(BYTES_W);
  localparam logic [STEP_W-1:0] STEPS_GOOD_DIV = STEP_W'(OPND_W);
  localparam logic [STEP_W-1:0] STEPS_INC_MUL  = STEP_W'(MSS_W);
  localparam logic [STEP_W-1:0] STEPS_INC_DIV  = STEP_W'(MSS_W + BYTES_W);

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [OPND_W-1:0] a;
    logic [DVSR_W-1:0] b;
    logic [STEP_W-1:0] steps;
  } mdu_req_t;

  typedef struct packed {
    logic              done;
    logic [OPND_W-1:0] result;
  } mdu_rsp_t;

  typedef struct packed {
    logic [MSS_W-1:0]   mss;
    logic [MINW_W-1:0]  min_window;
    logic               init_load;
    logic [INITW_W-1:0] initial_window;
  } cfg_t;

endpackage

>>> rtl/ecnaw_mdu.sv
// ----------------------------------------------------------------------------
// ecnaw_mdu
// shared iterative multiply and divide unit, one operand bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecnaw_mdu (
  input  logic                clk,
  input  logic                rst,
  input  ecnaw_pkg::mdu_req_t req,
  output ecnaw_pkg::mdu_rsp_t rsp
);
  import ecnaw_pkg::*;

  logic              busy;
  logic              done;
  op_t               op;
  logic [STEP_W-1:0] cnt;
  logic [OPND_W-1:0] sh;
  logic [OPND_W-1:0] acc;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] b_q;

  logic [DVSR_W:0]   rem_sh;
  logic [DVSR_W:0]   diff;
  logic              ge;
  logic [OPND_W-1:0] acc_step;

  always_comb begin
    rem_sh   = {rem, sh[OPND_W-1]};
    diff     = rem_sh - {1'b0, b_q};
    ge       = ~diff[DVSR_W];
    acc_step = {acc[OPND_W-2:0], 1'b0}
             + (sh[OPND_W-1] ? {{(OPND_W-DVSR_W){1'b0}}, b_q} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        sh   <= req.a;
        b_q  <= req.b;
        cnt  <= req.steps;
        acc  <= '0;
        rem  <= '0;
      end else if (busy) begin
        if (op == OP_MUL) begin
          acc <= acc_step;
          sh  <= {sh[OPND_W-2:0], 1'b0};
        end else begin
          rem <= ge ? diff[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
          sh  <= {sh[OPND_W-2:0], ge};
        end
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = (op == OP_MUL) ? acc : sh;

endmodule

>>> rtl/ecnaw_ctrl.sv
// ----------------------------------------------------------------------------
// ecnaw_ctrl
// per ack sequencer: era check, alpha update, window cut and increase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecnaw_ctrl #(
  parameter int GAIN_SHIFT = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ecnaw_pkg::cfg_t                  cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ecnaw_pkg::ACK_W-1:0]      ack_number,
  input  logic [ecnaw_pkg::ACK_W-1:0]      next_packet,
  input  logic [ecnaw_pkg::CNT_W-1:0]      ect1_total,
  input  logic [ecnaw_pkg::CNT_W-1:0]      ce_total,
  input  logic [ecnaw_pkg::BYTES_W-1:0]    acked_bytes,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ecnaw_pkg::WIN_W-1:0]      window,
  output logic [ecnaw_pkg::WIN_W-1:0]      threshold,
  output logic [ecnaw_pkg::ALPHA_W-1:0]    alpha_now,
  output ecnaw_pkg::mdu_req_t              req,
  input  ecnaw_pkg::mdu_rsp_t              rsp
);
  import ecnaw_pkg::*;

  localparam int ACC_W = ALPHA_W + GAIN_SHIFT + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_ERA, S_EDE, S_EDC, S_ESUM, S_EDEC, S_FRAC, S_ALPHA, S_CUTW,
    S_FLOOR, S_THR, S_ERAEND, S_LDE, S_LDC, S_LSUM, S_LDEC, S_GMW, S_GDW,
    S_IMW, S_IDW, S_SAT, S_DONE
  } state_t;

  state_t state;

  logic [ACK_W-1:0]   ack_q;
  logic [ACK_W-1:0]   snd_q;
  logic [CNT_W-1:0]   ect1_q;
  logic [CNT_W-1:0]   ce_q;
  logic [BYTES_W-1:0] bytes_q;

  logic [WIN_W-1:0]   cwnd;
  logic [WIN_W-1:0]   ssthresh;
  logic [ALPHA_W-1:0] alpha;
  logic [ACK_W-1:0]   era_end;
  logic [CNT_W-1:0]   era_ect1;
  logic [CNT_W-1:0]   era_ce;
  logic [CNT_W-1:0]   last_ect1;
  logic [CNT_W-1:0]   last_ce;

  logic               era_hit;
  logic [CNT_W-1:0]   d_e;
  logic [CNT_W-1:0]   d_c;
  logic               bor_e;
  logic               bor_c;
  logic [CNT_W:0]     dsum;
  logic [ALPHA_W-1:0] frac;
  logic [MSS_W+BYTES_W-1:0] inc;

  logic [ACC_W-1:0]   alpha_acc;
  logic [ACC_W-1:0]   alpha_shr;
  logic [ALPHA_W-1:0] alpha_next;
  logic [WIN_W-1:0]   div_base;
  logic [WIN_W:0]     cwnd_sum;

  always_comb begin
    alpha_acc  = (ACC_W'(alpha) << GAIN_SHIFT) - ACC_W'(alpha) + ACC_W'(frac);
    alpha_shr  = alpha_acc >> GAIN_SHIFT;
    alpha_next = (frac > alpha && frac >= ALPHA_HALF) ? frac : alpha_shr[ALPHA_W-1:0];
    div_base   = (cwnd == '0) ? WIN_W'(1) : cwnd;
    cwnd_sum   = {1'b0, cwnd} + (WIN_W+1)'(inc);
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      req.start <= 1'b0;
      cwnd      <= WIN_W'(INITW_RST);
      ssthresh  <= '1;
      alpha     <= '0;
      era_end   <= '0;
      era_ect1  <= '0;
      era_ce    <= '0;
      last_ect1 <= '0;
      last_ce   <= '0;
    end else begin
      req.start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.init_load) begin
        cwnd <= WIN_W'(cfg.initial_window);
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ack_q   <= ack_number;
            snd_q   <= next_packet;
            ect1_q  <= ect1_total;
            ce_q    <= ce_total;
            bytes_q <= acked_bytes;
            state   <= S_ERA;
          end
        end
        S_ERA: begin
          era_hit <= ack_q > era_end;
          state   <= S_EDE;
        end
        S_EDE: begin
          {bor_e, d_e} <= {1'b0, ect1_q} - {1'b0, era_ect1};
          state        <= S_EDC;
        end
        S_EDC: begin
          {bor_c, d_c} <= {1'b0, ce_q} - {1'b0, era_ce};
          state        <= S_ESUM;
        end
        S_ESUM: begin
          dsum  <= {1'b0, d_e} + {1'b0, d_c};
          state <= S_EDEC;
        end
        S_EDEC: begin
          if (!era_hit) begin
            state <= S_LDE;
          end else if (!bor_e && !bor_c && dsum != '0) begin
            req.start <= 1'b1;
            req.op    <= OP_DIV;
            req.a     <= {d_c, {(OPND_W-CNT_W){1'b0}}};
            req.b     <= DVSR_W'(dsum);
            req.steps <= STEPS_FRAC_DIV;
            state     <= S_FRAC;
          end else begin
            state <= S_ERAEND;
          end
        end
        S_FRAC: begin
          if (rsp.done) begin
            frac  <= rsp.result[ALPHA_W-1:0];
            state <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          alpha     <= alpha_next;
          req.start <= 1'b1;
          req.op    <= OP_MUL;
          req.a     <= {alpha_next, {(OPND_W-ALPHA_W){1'b0}}};
          req.b     <= cwnd;
          req.steps <= STEPS_CUT_MUL;
          state     <= S_CUTW;
        end
        S_CUTW: begin
          if (rsp.done) begin
            cwnd  <= cwnd - rsp.result[CUT_SHIFT +: WIN_W];
            state <= S_FLOOR;
          end
        end
        S_FLOOR: begin
          if (cwnd < WIN_W'(cfg.min_window)) begin
            cwnd <= WIN_W'(cfg.min_window);
          end
          state <= S_THR;
        end
        S_THR: begin
          ssthresh <= cwnd;
          state    <= S_ERAEND;
        end
        S_ERAEND: begin
          era_ect1 <= ect1_q;
          era_ce   <= ce_q;
          era_end  <= snd_q;
          state    <= S_LDE;
        end
        S_LDE: begin
          {bor_e, d_e} <= {1'b0, ect1_q} - {1'b0, last_ect1};
          state        <= S_LDC;
        end
        S_LDC: begin
          {bor_c, d_c} <= {1'b0, ce_q} - {1'b0, last_ce};
          state        <= S_LSUM;
        end
        S_LSUM: begin
          dsum  <= {1'b0, d_e} + {1'b0, d_c};
          state <= S_LDEC;
        end
        S_LDEC: begin
          if (bor_e || bor_c) begin
            state <= S_DONE;
          end else if (dsum == '0) begin
            req.start <= 1'b1;
            req.op    <= OP_MUL;
            req.a     <= {cfg.mss, {(OPND_W-MSS_W){1'b0}}};
            req.b     <= DVSR_W'(bytes_q);
            req.steps <= STEPS_INC_MUL;
            state     <= S_IMW;
          end else begin
            req.start <= 1'b1;
            req.op    <= OP_MUL;
            req.a     <= {bytes_q, {(OPND_W-BYTES_W){1'b0}}};
            req.b     <= DVSR_W'(d_e);
            req.steps <= STEPS_GOOD_MUL;
            state     <= S_GMW;
          end
        end
        S_GMW: begin
          if (rsp.done) begin
            req.start <= 1'b1;
            req.op    <= OP_DIV;
            req.a     <= rsp.result;
            req.b     <= DVSR_W'(dsum);
            req.steps <= STEPS_GOOD_DIV;
            state     <= S_GDW;
          end
        end
        S_GDW: begin
          if (rsp.done) begin
            req.start <= 1'b1;
            req.op    <= OP_MUL;
            req.a     <= {cfg.mss, {(OPND_W-MSS_W){1'b0}}};
            req.b     <= DVSR_W'(rsp.result[BYTES_W-1:0]);
            req.steps <= STEPS_INC_MUL;
            state     <= S_IMW;
          end
        end
        S_IMW: begin
          if (rsp.done) begin
            req.start <= 1'b1;
            req.op    <= OP_DIV;
            req.a     <= {rsp.result[MSS_W+BYTES_W-1:0],
                          {(OPND_W-MSS_W-BYTES_W){1'b0}}};
            req.b     <= div_base;
            req.steps <= STEPS_INC_DIV;
            state     <= S_IDW;
          end
        end
        S_IDW: begin
          if (rsp.done) begin
            inc   <= rsp.result[MSS_W+BYTES_W-1:0];
            state <= S_SAT;
          end
        end
        S_SAT: begin
          cwnd  <= cwnd_sum[WIN_W] ? '1 : cwnd_sum[WIN_W-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            last_ect1 <= ect1_q;
            last_ce   <= ce_q;
            window    <= cwnd;
            threshold <= ssthresh;
            alpha_now <= alpha;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/ecn_alpha_window_update_top.sv
// ----------------------------------------------------------------------------
// ecn_alpha_window_update_top
// One ACK in congestion avoidance updates the ECN smoothed CE fraction alpha
// and the congestion window. The block takes one transaction at a time:
// in_ready is high only while it is idle. A shared bit-serial multiply and
// divide unit does the arithmetic: a fraction division and a cut multiply
// when an ACK closes an era with new marks, a share multiply and division
// when the counts have moved since the last ACK, and an increase multiply
// and division unless the counts went backwards. The result sits in an
// output register, so the next ACK is taken while it waits; the ACK after
// that stalls in its last step until the held result is accepted.
// Configuration writes are taken at any time, with cfg_ready held high, and
// are meant for an idle block; writing initial_window also loads the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecn_alpha_window_update_top #(
  parameter int GAIN_SHIFT = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ecnaw_pkg::ACK_W-1:0]         ack_number,
  input  logic [ecnaw_pkg::ACK_W-1:0]         next_packet,
  input  logic [ecnaw_pkg::CNT_W-1:0]         ect1_total,
  input  logic [ecnaw_pkg::CNT_W-1:0]         ce_total,
  input  logic [ecnaw_pkg::BYTES_W-1:0]       acked_bytes,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ecnaw_pkg::WIN_W-1:0]         window,
  output logic [ecnaw_pkg::WIN_W-1:0]         threshold,
  output logic [ecnaw_pkg::ALPHA_W-1:0]       alpha_now,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ecnaw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecnaw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ecnaw_pkg::*;

  logic [MSS_W-1:0]   mss;
  logic [MINW_W-1:0]  min_window;
  logic [INITW_W-1:0] initial_window;
  logic               init_load;
  cfg_t               cfg;
  mdu_req_t           mdu_req;
  mdu_rsp_t           mdu_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mss            <= MSS_RST;
      min_window     <= MINW_RST;
      initial_window <= INITW_RST;
      init_load      <= 1'b0;
    end else begin
      init_load <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MSS: begin
            mss <= cfg_data[MSS_W-1:0];
          end
          CFG_MINW: begin
            min_window <= cfg_data[MINW_W-1:0];
          end
          CFG_INITW: begin
            initial_window <= cfg_data[INITW_W-1:0];
            init_load      <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    cfg.mss            = mss;
    cfg.min_window     = min_window;
    cfg.init_load      = init_load;
    cfg.initial_window = initial_window;
  end

  ecnaw_mdu u_mdu (
    .clk (clk),
    .rst (rst),
    .req (mdu_req),
    .rsp (mdu_rsp)
  );

  ecnaw_ctrl #(
    .GAIN_SHIFT (GAIN_SHIFT)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ack_number    (ack_number),
    .next_packet   (next_packet),
    .ect1_total    (ect1_total),
    .ce_total      (ce_total),
    .acked_bytes   (acked_bytes),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .window        (window),
    .threshold     (threshold),
    .alpha_now     (alpha_now),
    .req           (mdu_req),
    .rsp           (mdu_rsp)
  );

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alpha_now <= ALPHA_ONE)
    else $error("alpha above one");

  a_mdu_seq: assert property (@(posedge clk) disable iff (rst)
    mdu_rsp.done |-> !mdu_req.start)
    else $error("shared unit restarted while finishing");

endmodule

>>> tb/tb_ecn_alpha_window_update_top.sv
// ----------------------------------------------------------------------------
// tb_ecn_alpha_window_update_top
// Drives ACK transactions into the ECN alpha and window update block and
// checks every result against a cycle-free predictor of the window,
// threshold and alpha. A directed opening covers field extremes, era ends
// with and without new marks, counts that go backwards and a zero window.
// Random phases then run well-formed ACK streams at several congestion
// levels and register settings, mixed with broken and random transactions,
// while both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ecn_alpha_window_update_top;
  import ecnaw_pkg::*;

  localparam int GAIN_SHIFT    = 4;
  localparam int PHASES        = 10;
  localparam int PHASE_ACKS    = 70;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [ACK_W-1:0]   ACK_MAX   = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [WIN_W-1:0]   WIN_MAX   = '1;
  localparam logic [ACK_W-1:0]   ACK_ROOM  = 62'd1048576;
  localparam logic [CNT_W-1:0]   CNT_ROOM  = 40'd1048576;

  typedef enum logic [1:0] {
    ST_ACK,
    ST_CFG,
    ST_DRAIN
  } step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [ACK_W-1:0]      ack_number;
    logic [ACK_W-1:0]      next_packet;
    logic [CNT_W-1:0]      ect1_total;
    logic [CNT_W-1:0]      ce_total;
    logic [BYTES_W-1:0]    acked_bytes;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           gap;
  } step_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window;
    logic [WIN_W-1:0]   threshold;
    logic [ALPHA_W-1:0] alpha_now;
  } ack_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [ACK_W-1:0]      ack_number    = '0;
  logic [ACK_W-1:0]      next_packet   = '0;
  logic [CNT_W-1:0]      ect1_total    = '0;
  logic [CNT_W-1:0]      ce_total      = '0;
  logic [BYTES_W-1:0]    acked_bytes   = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [WIN_W-1:0]      window;
  logic [WIN_W-1:0]      threshold;
  logic [ALPHA_W-1:0]    alpha_now;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_MSS;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // predictor state
  logic [MSS_W-1:0]   mss_q;
  logic [MINW_W-1:0]  floor_win;
  logic [WIN_W-1:0]   win_q;
  logic [WIN_W-1:0]   ssth_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [ACK_W-1:0]   epoch_end;
  logic [CNT_W-1:0]   epoch_ect1;
  logic [CNT_W-1:0]   epoch_ce;
  logic [CNT_W-1:0]   prev_ect1;
  logic [CNT_W-1:0]   prev_ce;

  step_t        ack_plan[$];
  ack_outcome_t pending_windows[$];
  step_t        cur_ack;
  step_t        cur_cfg;
  int unsigned  gap_left;
  int unsigned  settle;
  int unsigned  stall_left;
  int unsigned  results_seen;
  int unsigned  err_count;
  int unsigned  cycle_count;

  ecn_alpha_window_update_top #(
    .GAIN_SHIFT(GAIN_SHIFT)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ack_number   (ack_number),
    .next_packet  (next_packet),
    .ect1_total   (ect1_total),
    .ce_total     (ce_total),
    .acked_bytes  (acked_bytes),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .window       (window),
    .threshold    (threshold),
    .alpha_now    (alpha_now),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MSS:   mss_q = data[MSS_W-1:0];
      CFG_MINW:  floor_win = data[MINW_W-1:0];
      CFG_INITW: win_q = WIN_W'(data[INITW_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic ack_outcome_t ack_window_update(input step_t a);
    logic [63:0]      d1;
    logic [63:0]      dc;
    logic [63:0]      frac;
    logic [63:0]      acc;
    logic [63:0]      good;
    logic [63:0]      divisor;
    logic [63:0]      inc;
    logic [WIN_W-1:0] room;
    ack_outcome_t     r;
    if (a.ack_number > epoch_end) begin
      if (a.ect1_total >= epoch_ect1 && a.ce_total >= epoch_ce) begin
        d1 = 64'(a.ect1_total) - 64'(epoch_ect1);
        dc = 64'(a.ce_total) - 64'(epoch_ce);
        if (d1 + dc != 0) begin
          frac = 0;
          if (dc != 0) frac = (dc << FRAC_SHIFT) / (dc + d1);
          if (frac > 64'(alpha_q) && frac >= 64'(ALPHA_HALF)) begin
            alpha_q = ALPHA_W'(frac);
          end else begin
            acc = (64'(alpha_q) << GAIN_SHIFT) - 64'(alpha_q) + frac;
            alpha_q = ALPHA_W'(acc >> GAIN_SHIFT);
          end
          win_q = win_q - WIN_W'((64'(win_q) * 64'(alpha_q)) >> CUT_SHIFT);
          if (win_q < WIN_W'(floor_win)) win_q = WIN_W'(floor_win);
          ssth_q = win_q;
        end
      end
      epoch_ect1 = a.ect1_total;
      epoch_ce   = a.ce_total;
      epoch_end  = a.next_packet;
    end
    if (a.ect1_total >= prev_ect1 && a.ce_total >= prev_ce) begin
      d1 = 64'(a.ect1_total) - 64'(prev_ect1);
      dc = 64'(a.ce_total) - 64'(prev_ce);
      good = 64'(a.acked_bytes);
      if (d1 + dc != 0) good = (d1 * 64'(a.acked_bytes)) / (d1 + dc);
      divisor = (win_q == '0) ? 64'd1 : 64'(win_q);
      inc = (64'(mss_q) * good) / divisor;
      room = WIN_MAX - win_q;
      if (inc > 64'(room)) win_q = WIN_MAX;
      else win_q = win_q + WIN_W'(inc);
    end
    prev_ect1 = a.ect1_total;
    prev_ce   = a.ce_total;
    r.window    = win_q;
    r.threshold = ssth_q;
    r.alpha_now = alpha_q;
    return r;
  endfunction

  function automatic void add_ack(input logic [ACK_W-1:0] a, input logic [ACK_W-1:0] s,
                                  input logic [CNT_W-1:0] e, input logic [CNT_W-1:0] c,
                                  input logic [BYTES_W-1:0] b, input int unsigned g);
    step_t t;
    t = '0;
    t.kind          = ST_ACK;
    t.ack_number    = a;
    t.next_packet   = s;
    t.ect1_total    = e;
    t.ce_total      = c;
    t.acked_bytes   = b;
    t.gap           = g;
    ack_plan.push_back(t);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    step_t t;
    t = '0;
    t.kind      = ST_CFG;
    t.cfg_index = idx;
    t.cfg_data  = data;
    ack_plan.push_back(t);
  endfunction

  function automatic void add_drain();
    step_t t;
    t = '0;
    t.kind = ST_DRAIN;
    ack_plan.push_back(t);
  endfunction

  function automatic logic [BYTES_W-1:0] rand_bytes();
    if ($urandom_range(0, 6) == 0) return BYTES_W'($urandom);
    return BYTES_W'($urandom_range(0, 20000));
  endfunction

  // stimulus plan
  initial begin : plan
    int unsigned       mss_pick[PHASES]   = '{1280, 1, 65535, 0, 1460, 0, 65535, 1, 0, 536};
    int unsigned       minw_pick[PHASES]  = '{2560, 1, 1048576, 0, 1, 1048576, 0, 2560, 0, 1};
    int unsigned       initw_pick[PHASES] = '{15360, 16777215, 1, 0, 100000, 0, 16777215, 1, 0,
                                              4000};
    int unsigned       ce_level[PHASES]   = '{1, 3, 6, 8, 0, 2, 5, 7, 4, 8};
    logic [ACK_W-1:0]  ack_pos;
    logic [ACK_W-1:0]  snd_pos;
    logic [CNT_W-1:0]  e_pos;
    logic [CNT_W-1:0]  c_pos;
    int unsigned       v;
    int unsigned       g;
    int unsigned       sel;
    int unsigned       pkts;
    bit                calm;

    add_ack(0, 5, 0, 0, 0, $urandom_range(0, 11));
    add_ack(1, 10, 10, 0, 1200, $urandom_range(0, 11));
    add_ack(5, 12, 12, 10, BYTES_MAX, $urandom_range(0, 11));
    add_ack(11, 20, 12, 30, 3000, $urandom_range(0, 11));
    add_ack(21, 30, 12, 30, 500, $urandom_range(0, 11));
    add_ack(31, 40, 5, 31, 500, $urandom_range(0, 11));
    add_ack(32, 41, 20, 40, 800, $urandom_range(0, 11));
    add_ack(41, 50, 60, 45, 800, $urandom_range(0, 11));
    add_ack(51, 60, 60, 46, 0, $urandom_range(0, 11));
    add_ack(ACK_MAX, 0, CNT_MAX, CNT_MAX, BYTES_MAX, $urandom_range(0, 11));
    add_ack(1, 3, 0, 0, 100, $urandom_range(0, 11));
    add_ack(4, 8, 0, 4, 100, $urandom_range(0, 11));
    // zero window: increase divides by one
    add_cfg(CFG_INITW, '0);
    add_ack(4, 8, 0, 4, 1000, $urandom_range(0, 11));
    add_ack(9, 12, 3, 9, 2000, $urandom_range(0, 11));

    for (int p = 0; p < PHASES; p++) begin
      // zero in a pick list: draw at random
      v = (mss_pick[p] != 0) ? mss_pick[p] : $urandom_range(1, 65535);
      add_cfg(CFG_MSS, CFG_DATA_W'(v));
      v = (minw_pick[p] != 0) ? minw_pick[p] : $urandom_range(1, 1048576);
      add_cfg(CFG_MINW, CFG_DATA_W'(v));
      v = (initw_pick[p] != 0) ? initw_pick[p] : $urandom_range(1, 16777215);
      add_cfg(CFG_INITW, CFG_DATA_W'(v));

      calm    = (p == 3 || p == 7);
      ack_pos = ACK_W'({$urandom, $urandom});
      if (ack_pos > ACK_MAX - ACK_ROOM) ack_pos = ack_pos - ACK_ROOM;
      snd_pos = ack_pos + ACK_W'($urandom_range(1, 8));
      e_pos   = CNT_W'({$urandom, $urandom});
      if (e_pos > CNT_MAX - CNT_ROOM) e_pos = e_pos - CNT_ROOM;
      c_pos   = CNT_W'({$urandom, $urandom});
      if (c_pos > CNT_MAX - CNT_ROOM) c_pos = c_pos - CNT_ROOM;
      // an all-ones ack closes whatever era is open and restarts it here
      add_ack(ACK_MAX, snd_pos, e_pos, c_pos, rand_bytes(), calm ? 0 : $urandom_range(0, 11));

      for (int i = 0; i < PHASE_ACKS; i++) begin
        if (i == PHASE_ACKS / 2) add_drain();
        g   = calm ? 0 : $urandom_range(0, 11);
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          if ($urandom_range(0, 1) == 1) begin
            add_ack(ack_pos, snd_pos, e_pos - CNT_W'($urandom_range(1, 3)), c_pos,
                    rand_bytes(), g);
          end else begin
            add_ack(ack_pos, snd_pos, e_pos, c_pos - CNT_W'($urandom_range(1, 3)),
                    rand_bytes(), g);
          end
        end else if (sel < 10) begin
          add_ack(ack_pos, snd_pos, e_pos, c_pos, rand_bytes(), g);
        end else if (sel < 12) begin
          add_ack(ACK_W'({$urandom, $urandom}), ACK_W'({$urandom, $urandom}),
                  CNT_W'({$urandom, $urandom}), CNT_W'({$urandom, $urandom}),
                  BYTES_W'($urandom), g);
          add_ack(ACK_MAX, snd_pos, e_pos, c_pos, rand_bytes(), g);
        end else begin
          pkts = $urandom_range(0, 6);
          for (int k = 0; k < pkts; k++) begin
            if ($urandom_range(0, 7) < ce_level[p]) c_pos = c_pos + 1'b1;
            else e_pos = e_pos + 1'b1;
          end
          ack_pos = ack_pos + ACK_W'($urandom_range(1, 4));
          if (snd_pos <= ack_pos) snd_pos = ack_pos + 1'b1;
          snd_pos = snd_pos + ACK_W'($urandom_range(0, 3));
          add_ack(ack_pos, snd_pos, e_pos, c_pos, rand_bytes(), g);
        end
      end
    end
    // an all-ones era end can never be passed again, so it comes last
    add_ack(ack_pos + 1'b1, ACK_MAX, e_pos, c_pos, BYTES_MAX, 0);
  end

  // driver
  always @(posedge clk) begin : driver
    logic in_hold;
    logic cfg_hold;
    if (rst) begin
      in_valid   <= 1'b0;
      cfg_valid  <= 1'b0;
      gap_left   = 0;
      settle     = 0;
      mss_q      = MSS_RST;
      floor_win  = MINW_RST;
      win_q      = WIN_W'(INITW_RST);
      ssth_q     = WIN_MAX;
      alpha_q    = '0;
      epoch_end  = '0;
      epoch_ect1 = '0;
      epoch_ce   = '0;
      prev_ect1  = '0;
      prev_ce    = '0;
    end else begin
      in_hold  = in_valid && !in_ready;
      cfg_hold = cfg_valid && !cfg_ready;
      if (in_valid && in_ready) pending_windows.push_back(ack_window_update(cur_ack));
      if (cfg_valid && cfg_ready) load_register(cur_cfg.cfg_index, cur_cfg.cfg_data);
      if (pending_windows.size() == 0 && !in_valid) settle++;
      else settle = 0;
      if (!in_hold && !cfg_hold) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (ack_plan.size() != 0) begin
          case (ack_plan[0].kind)
            ST_ACK: begin
              cur_ack = ack_plan.pop_front();
              ack_number    <= cur_ack.ack_number;
              next_packet   <= cur_ack.next_packet;
              ect1_total    <= cur_ack.ect1_total;
              ce_total      <= cur_ack.ce_total;
              acked_bytes   <= cur_ack.acked_bytes;
              gap_left = cur_ack.gap;
              in_hold  = 1'b1;
            end
            ST_CFG: begin
              if (settle >= SETTLE_CYCLES) begin
                cur_cfg = ack_plan.pop_front();
                cfg_index <= cur_cfg.cfg_index;
                cfg_data  <= cur_cfg.cfg_data;
                cfg_hold = 1'b1;
              end
            end
            default: begin
              if (settle >= SETTLE_CYCLES) void'(ack_plan.pop_front());
            end
          endcase
        end
      end
      in_valid  <= in_hold;
      cfg_valid <= cfg_hold;
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    ack_outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_windows.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction window=%0d", window));
        end else begin
          want = pending_windows.pop_front();
          if (window !== want.window)
            report_mismatch($sformatf("window got %0d want %0d", window, want.window));
          if (threshold !== want.threshold)
            report_mismatch($sformatf("threshold got %0d want %0d", threshold,
                                      want.threshold));
          if (alpha_now !== want.alpha_now)
            report_mismatch($sformatf("alpha_now got %0d want %0d", alpha_now,
                                      want.alpha_now));
        end
        results_seen++;
        stall_left = (((results_seen / 40) % 5) == 2) ? 0 : $urandom_range(0, 11);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : run_limit
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** ecn_alpha_window_update_top: FAILED **");
    $finish;
  end

  initial begin : wrap_up
    err_count    = 0;
    results_seen = 0;
    do @(negedge clk);
    while (rst || ack_plan.size() != 0 || in_valid || cfg_valid || pending_windows.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("** ecn_alpha_window_update_top: PASSED **");
    end else begin
      $display("** ecn_alpha_window_update_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ecnaw_pkg.sv
rtl/ecnaw_mdu.sv
rtl/ecnaw_ctrl.sv
rtl/ecn_alpha_window_update_top.sv
tb/tb_ecn_alpha_window_update_top.sv
